// ===== design/chacha20_stream_xor_top_assert.svh =====
// Assertion macros for the ChaCha20 stream XOR block.
`ifndef CHACHA20_STREAM_XOR_TOP_ASSERT_SVH
`define CHACHA20_STREAM_XOR_TOP_ASSERT_SVH

`ifndef SYNTH
`define CSX_ASSERT_IMP(name, clk_i, rst_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CSX_ASSERT_NEXT(name, clk_i, rst_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSX_ASSERT_IMP(name, clk_i, rst_i, ante, cons)
`define CSX_ASSERT_NEXT(name, clk_i, rst_i, ante, cons)
`endif

`endif

// ===== design/csx_pkg.sv =====
// Shared types, constants and state helpers for the ChaCha20 stream XOR block.
package csx_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_0_7    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_8_15   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_16_23  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_24_31  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR   = 3'd6;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam logic [3:0]  LAST_DR       = 4'(DOUBLE_ROUNDS - 1);

  typedef logic [31:0]       csx_word_t;
  typedef logic [15:0][31:0] csx_state_t;

  localparam csx_word_t SIGMA_0 = 32'h61707865;
  localparam csx_word_t SIGMA_1 = 32'h3320646e;
  localparam csx_word_t SIGMA_2 = 32'h79622d32;
  localparam csx_word_t SIGMA_3 = 32'h6b206574;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_lo;
    logic [31:0]      nonce_hi;
    logic [31:0]      init_ctr;
  } csx_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } csx_gen_stat_t;

  // quarter-round step: which pair is added and the rotate amount
  typedef enum logic [1:0] {ST_A16, ST_C12, ST_A8, ST_C7} csx_step_t;

  typedef enum logic [1:0] {SH_ONE, SH_DIAG, SH_UNDIAG} csx_shift_t;

  function automatic csx_word_t csx_init_word(csx_cfg_t cfg, csx_word_t ctr, logic [3:0] idx);
    csx_word_t w;
    unique case (idx)
      4'd0:  w = SIGMA_0;
      4'd1:  w = SIGMA_1;
      4'd2:  w = SIGMA_2;
      4'd3:  w = SIGMA_3;
      4'd4:  w = cfg.key[0][31:0];
      4'd5:  w = cfg.key[0][63:32];
      4'd6:  w = cfg.key[1][31:0];
      4'd7:  w = cfg.key[1][63:32];
      4'd8:  w = cfg.key[2][31:0];
      4'd9:  w = cfg.key[2][63:32];
      4'd10: w = cfg.key[3][31:0];
      4'd11: w = cfg.key[3][63:32];
      4'd12: w = ctr;
      4'd13: w = cfg.nonce_lo[31:0];
      4'd14: w = cfg.nonce_lo[63:32];
      4'd15: w = cfg.nonce_hi;
    endcase
    return w;
  endfunction

  function automatic csx_state_t csx_init_state(csx_cfg_t cfg, csx_word_t ctr);
    csx_state_t s;
    for (int i = 0; i < 16; i++) begin
      s[i] = csx_init_word(cfg, ctr, 4'(i));
    end
    return s;
  endfunction

  function automatic logic [1:0] csx_row_shift(csx_shift_t sel, logic [1:0] row);
    logic [1:0] k;
    unique case (sel)
      SH_ONE:    k = 2'd1;
      SH_DIAG:   k = row + 2'd1;
      SH_UNDIAG: k = 2'd1 - row;
      default:   k = 2'd1;
    endcase
    return k;
  endfunction

  // rotate each 4-word row left; fixed wiring per select
  function automatic csx_state_t csx_shift_rows(csx_state_t s, csx_shift_t sel);
    csx_state_t o;
    logic [1:0] k;
    logic [1:0] col;
    for (int r = 0; r < 4; r++) begin
      for (int i = 0; i < 4; i++) begin
        k = csx_row_shift(sel, 2'(r));
        col = 2'(i) + k;
        o[r*4 + i] = s[r*4 + int'(col)];
      end
    end
    return o;
  endfunction

endpackage

// ===== design/csx_stream_if.sv =====
// Valid/ready stream interfaces for the input and output channels.
interface csx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       start_of_message;

  modport source (output valid, output data_in, output start_of_message, input ready);
  modport sink (input valid, input data_in, input start_of_message, output ready);
endinterface

interface csx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink (input valid, input data_out, output ready);
endinterface

// ===== design/csx_arx_unit.sv =====
// Shared add-xor-rotate unit: one quarter-round step per cycle.
module csx_arx_unit import csx_pkg::*; (
  input  csx_step_t step,
  input  csx_word_t x,
  input  csx_word_t y,
  input  csx_word_t z,
  output csx_word_t sum,
  output csx_word_t mix
);

  csx_word_t v;

  assign sum = x + y;
  assign v   = z ^ sum;

  always_comb begin
    unique case (step)
      ST_A16: mix = {v[15:0], v[31:16]};
      ST_C12: mix = {v[19:0], v[31:20]};
      ST_A8:  mix = {v[23:0], v[31:24]};
      ST_C7:  mix = {v[24:0], v[31:25]};
      default: mix = v;
    endcase
  end

endmodule

// ===== design/csx_block_gen.sv =====
// Keystream block generator: round sequencer, working state and keystream RAM.
module csx_block_gen import csx_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  csx_cfg_t      cfg,
  input  csx_word_t     ctr,
  input  logic [3:0]    rd_addr,
  output csx_word_t     rd_data,
  output csx_gen_stat_t stat
);

  typedef enum logic [1:0] {G_IDLE, G_ROUND, G_FINAL} gen_state_t;

  gen_state_t state;
  csx_state_t w;
  csx_state_t w_step;
  csx_step_t  step;
  logic [2:0] qr;
  logic [3:0] dr;
  logic [3:0] fidx;
  logic       gen_done;
  logic       odd;
  logic       final_ph;
  csx_shift_t shift_sel;
  csx_word_t  x;
  csx_word_t  y;
  csx_word_t  z;
  csx_word_t  sum;
  csx_word_t  mix;
  csx_word_t  ks_mem [16];

  assign final_ph = (state == G_FINAL);
  assign odd      = (step == ST_C12) || (step == ST_C7);
  assign stat     = '{busy: (state != G_IDLE), done: gen_done};

  // the quarter round always works on column 0; rows rotate between quarter rounds
  always_comb begin
    if (final_ph) begin
      x = w[0];
      y = csx_init_word(cfg, ctr, fidx);
      z = w[12];
    end else if (odd) begin
      x = w[8];
      y = w[12];
      z = w[4];
    end else begin
      x = w[0];
      y = w[4];
      z = w[12];
    end
  end

  csx_arx_unit u_arx (
    .step (step),
    .x    (x),
    .y    (y),
    .z    (z),
    .sum  (sum),
    .mix  (mix)
  );

  always_comb begin
    w_step = w;
    if (odd) begin
      w_step[8] = sum;
      w_step[4] = mix;
    end else begin
      w_step[0]  = sum;
      w_step[12] = mix;
    end
    priority if (qr == 3'd3) begin
      shift_sel = SH_DIAG;
    end else if (qr == 3'd7) begin
      shift_sel = SH_UNDIAG;
    end else begin
      shift_sel = SH_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= G_IDLE;
      gen_done <= 1'b0;
    end else begin
      gen_done <= final_ph && (fidx == 4'd15);
      unique case (state)
        G_IDLE: begin
          if (start) begin
            w     <= csx_init_state(cfg, ctr);
            step  <= ST_A16;
            qr    <= 3'd0;
            dr    <= 4'd0;
            state <= G_ROUND;
          end
        end
        G_ROUND: begin
          step <= csx_step_t'(step + 2'd1);
          if (step == ST_C7) begin
            w  <= csx_shift_rows(w_step, shift_sel);
            qr <= qr + 3'd1;
            if (qr == 3'd7) begin
              dr <= dr + 4'd1;
              if (dr == LAST_DR) begin
                fidx  <= 4'd0;
                state <= G_FINAL;
              end
            end
          end else begin
            w <= w_step;
          end
        end
        G_FINAL: begin
          w    <= {w[0], w[15:1]};
          fidx <= fidx + 4'd1;
          if (fidx == 4'd15) begin
            state <= G_IDLE;
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (final_ph) begin
      ks_mem[fidx] <= sum;
    end
    rd_data <= ks_mem[rd_addr];
  end

endmodule

// ===== design/chacha20_stream_xor_top.sv =====
// ChaCha20 stream XOR: each transferred byte is XORed with the next keystream byte
// (RFC 8439 block function, 32-bit wrapping block counter, 96-bit nonce). A byte at
// block position 0 first generates a new 64-byte block: one shared add-xor-rotate unit
// runs 320 steps (10 double rounds, 8 quarter rounds, 4 steps each), then the input state
// is added word by word into the 16-word keystream RAM. Every other byte passes through
// transfer, RAM read and output register, and waits while the output is stalled. Key
// and nonce are sampled when a block is generated; start_of_message reloads the counter
// and restarts at position 0.
`include "chacha20_stream_xor_top_assert.svh"

module chacha20_stream_xor_top import csx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  csx_in_if.sink                in_ch,
  csx_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {T_IDLE, T_GEN, T_READ, T_EMIT} top_state_t;

  top_state_t    state;
  csx_cfg_t      cfg;
  csx_word_t     ctr;
  logic [5:0]    pos;
  logic [5:0]    cur_pos;
  logic [5:0]    eff_pos;
  logic [7:0]    data;
  logic [7:0]    ks_byte;
  logic          out_valid;
  logic [7:0]    out_data;
  logic          gen_start;
  logic          accept;
  csx_word_t     rd_data;
  csx_gen_stat_t gstat;

  assign in_ch.ready     = (state == T_IDLE);
  assign accept          = in_ch.valid && in_ch.ready;
  assign eff_pos         = in_ch.start_of_message ? 6'd0 : pos;
  assign out_ch.valid    = out_valid;
  assign out_ch.data_out = out_data;

  always_comb begin
    unique case (cur_pos[1:0])
      2'd0: ks_byte = rd_data[7:0];
      2'd1: ks_byte = rd_data[15:8];
      2'd2: ks_byte = rd_data[23:16];
      2'd3: ks_byte = rd_data[31:24];
      default: ks_byte = rd_data[7:0];
    endcase
  end

  csx_block_gen u_gen (
    .clk     (clk),
    .rst     (rst),
    .start   (gen_start),
    .cfg     (cfg),
    .ctr     (ctr),
    .rd_addr (cur_pos[5:2]),
    .rd_data (rd_data),
    .stat    (gstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      cfg       <= '0;
      ctr       <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
      gen_start <= 1'b0;
    end else begin
      gen_start <= accept && (eff_pos == 6'd0);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_0_7:   cfg.key[0]   <= cfg_data;
          CFG_KEY_8_15:  cfg.key[1]   <= cfg_data;
          CFG_KEY_16_23: cfg.key[2]   <= cfg_data;
          CFG_KEY_24_31: cfg.key[3]   <= cfg_data;
          CFG_NONCE_LO:  cfg.nonce_lo <= cfg_data;
          CFG_NONCE_HI:  cfg.nonce_hi <= cfg_data[31:0];
          CFG_INIT_CTR:  cfg.init_ctr <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (out_valid && out_ch.ready && (state != T_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            data    <= in_ch.data_in;
            cur_pos <= eff_pos;
            pos     <= eff_pos + 6'd1;
            if (in_ch.start_of_message) begin
              ctr <= cfg.init_ctr;
            end
            if (eff_pos == 6'd0) begin
              state <= T_GEN;
            end else begin
              state <= T_READ;
            end
          end
        end
        T_GEN: begin
          if (gstat.done) begin
            ctr   <= ctr + 32'd1;
            state <= T_READ;
          end
        end
        T_READ: state <= T_EMIT;
        T_EMIT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_data  <= data ^ ks_byte;
            state     <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  `CSX_ASSERT_IMP(a_done_in_gen, clk, rst, gstat.done, state == T_GEN)
  `CSX_ASSERT_IMP(a_start_gen_idle, clk, rst, gen_start, !gstat.busy)
  `CSX_ASSERT_NEXT(a_sop_pos, clk, rst, accept && in_ch.start_of_message, pos == 6'd1)
  `CSX_ASSERT_NEXT(a_ctr_step, clk, rst, gstat.done, ctr == $past(ctr) + 32'd1)

endmodule

// ===== dv/tb_chacha20_stream_xor_top.sv =====
// Testbench for chacha20_stream_xor_top: directed and random byte streams checked against a keystream predictor.
module tb_chacha20_stream_xor_top;
  import csx_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int CYCLE_LIMIT    = 1_500_000;
  localparam int HOLD_CYCLES    = 600;
  localparam int N_PHASES       = 12;
  localparam int PHASE_ITEMS    = 66;
  localparam int PRESSURE_ITEMS = 40;
  localparam int DRAIN_CYCLES   = 40;
  localparam int N_DIR          = 18;

  typedef struct packed {
    logic [7:0] data;
    logic       som;
    logic       typed;
    logic [7:0] want;
  } dir_row_t;

  // zero key, zero nonce, counter 0: keystream starts 76 b8
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{8'h00, 1'b0, 1'b1, 8'h76},
    '{8'hFF, 1'b0, 1'b1, 8'h47},
    '{8'h80, 1'b0, 1'b0, 8'h00},
    '{8'h7F, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b1, 8'h76},
    '{8'hFF, 1'b1, 1'b1, 8'h89},
    '{8'h01, 1'b0, 1'b1, 8'hB9},
    '{8'h55, 1'b0, 1'b0, 8'h00},
    '{8'hAA, 1'b0, 1'b0, 8'h00},
    '{8'h0F, 1'b0, 1'b0, 8'h00},
    '{8'hF0, 1'b0, 1'b0, 8'h00},
    '{8'h01, 1'b0, 1'b0, 8'h00},
    '{8'h02, 1'b0, 1'b0, 8'h00},
    '{8'h04, 1'b0, 1'b0, 8'h00},
    '{8'h08, 1'b0, 1'b0, 8'h00},
    '{8'h10, 1'b0, 1'b0, 8'h00},
    '{8'h20, 1'b0, 1'b0, 8'h00},
    '{8'h40, 1'b0, 1'b0, 8'h00}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  csx_in_if  in_ch();
  csx_out_if out_ch();

  chacha20_stream_xor_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [63:0] key_r [4];
  logic [63:0] nonce_lo_r;
  logic [31:0] nonce_hi_r;
  logic [31:0] ctr_init_r;
  logic [31:0] ks_words [16];
  logic [31:0] mix [16];
  logic [31:0] blk_ctr;
  logic [5:0]  byte_pos;

  logic [7:0] expected_bytes [$];
  logic [7:0] want_byte;
  int         err_cnt;
  int         cycle_cnt;
  int         tx_idle_pct;
  int         rx_idle_pct;
  bit         hold_req;
  int         hold_left;

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void mix_quarter(int a, int b, int c, int d);
    mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
  endfunction

  function automatic void next_keystream_block();
    logic [31:0] init [16];
    // "expand 32-byte k"
    init[0] = 32'h61707865;
    init[1] = 32'h3320646e;
    init[2] = 32'h79622d32;
    init[3] = 32'h6b206574;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2*i] = key_r[i][31:0];
      init[5 + 2*i] = key_r[i][63:32];
    end
    init[12] = blk_ctr;
    init[13] = nonce_lo_r[31:0];
    init[14] = nonce_lo_r[63:32];
    init[15] = nonce_hi_r;
    for (int i = 0; i < 16; i++) mix[i] = init[i];
    for (int r = 0; r < 10; r++) begin
      mix_quarter(0, 4, 8, 12);
      mix_quarter(1, 5, 9, 13);
      mix_quarter(2, 6, 10, 14);
      mix_quarter(3, 7, 11, 15);
      mix_quarter(0, 5, 10, 15);
      mix_quarter(1, 6, 11, 12);
      mix_quarter(2, 7, 8, 13);
      mix_quarter(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = mix[i] + init[i];
    blk_ctr = blk_ctr + 32'd1;
  endfunction

  function automatic logic [7:0] keystream_xor(logic [7:0] d, logic som);
    logic [31:0] w;
    if (som) begin
      blk_ctr  = ctr_init_r;
      byte_pos = 6'd0;
    end
    if (byte_pos == 6'd0) next_keystream_block();
    w = ks_words[byte_pos[5:2]] >> {byte_pos[1:0], 3'b000};
    byte_pos = byte_pos + 6'd1;
    return d ^ w[7:0];
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    case (idx)
      CFG_KEY_0_7:   key_r[0]   = val;
      CFG_KEY_8_15:  key_r[1]   = val;
      CFG_KEY_16_23: key_r[2]   = val;
      CFG_KEY_24_31: key_r[3]   = val;
      CFG_NONCE_LO:  nonce_lo_r = val;
      CFG_NONCE_HI:  nonce_hi_r = val[31:0];
      CFG_INIT_CTR:  ctr_init_r = val[31:0];
      default: ;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random back-pressure plus a long hold-off whenever hold_req is set
  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected data_out transfer, expected none, actual %02h",
                 $time, out_ch.data_out);
      end else begin
        want_byte = expected_bytes.pop_front();
        if (out_ch.data_out !== want_byte) begin
          err_cnt++;
          $display("%0t: data_out mismatch, expected %02h, actual %02h",
                   $time, want_byte, out_ch.data_out);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic s, input logic typed,
                           input logic [7:0] want);
    int gap;
    logic [7:0] got;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.data_in          <= d;
    in_ch.start_of_message <= s;
    do @(posedge clk); while (!in_ch.ready);
    got = keystream_xor(d, s);
    expected_bytes.push_back(typed ? want : got);
  endtask

  // called right after a transfer; valid is lowered once, then wait for the output side
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_reg_write(idx, val);
  endtask

  task automatic program_regs(input int p);
    logic [63:0] v [7];
    int sel;
    for (int i = 0; i < 7; i++) begin
      if (p == 0)      v[i] = '1;
      else if (p == 1) v[i] = '0;
      else             v[i] = {$urandom, $urandom};
    end
    if (p > 1) begin
      sel = $urandom_range(3);
      if (sel == 0)      v[6][31:0] = 32'h0;
      else if (sel == 1) v[6][31:0] = 32'hFFFF_FFFF;
      else if (sel == 2) v[6][31:0] = 32'hFFFF_FFFE;
    end
    write_reg(CFG_KEY_0_7,   v[0]);
    write_reg(CFG_KEY_8_15,  v[1]);
    write_reg(CFG_KEY_16_23, v[2]);
    write_reg(CFG_KEY_24_31, v[3]);
    write_reg(CFG_NONCE_LO,  v[4]);
    write_reg(CFG_NONCE_HI,  v[5]);
    write_reg(CFG_INIT_CTR,  v[6]);
    write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int p, input int n_items);
    int left;
    int msg_len;
    int r;
    bit first;
    bit start_msg;
    left  = n_items;
    first = 1'b1;
    while (left > 0) begin
      r = $urandom_range(9);
      if (p == 0 && first) msg_len = 130;
      else if (r < 6)      msg_len = $urandom_range(1, 40);
      else if (r < 9)      msg_len = $urandom_range(41, 140);
      else                 msg_len = 1;
      if (msg_len > left) msg_len = left;
      // some phases continue the running stream across the register update
      start_msg = first ? (p % 4 != 3) : ($urandom_range(4) != 0);
      for (int k = 0; k < msg_len; k++)
        send_byte(8'($urandom_range(255)),
                  (k == 0) ? start_msg : ($urandom_range(49) == 0), 1'b0, 8'h00);
      left -= msg_len;
      first = 1'b0;
    end
  endtask

  initial begin
    int saved_idle;
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    in_ch.valid            = 1'b0;
    in_ch.data_in          = 8'h00;
    in_ch.start_of_message = 1'b0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    hold_req    = 1'b0;
    tx_idle_pct = 20;
    rx_idle_pct = 79;
    for (int i = 0; i < 4; i++) key_r[i] = '0;
    nonce_lo_r = '0;
    nonce_hi_r = '0;
    ctr_init_r = '0;
    blk_ctr    = '0;
    byte_pos   = '0;
    for (int i = 0; i < 16; i++) ks_words[i] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++)
      send_byte(DIR_ROWS[i].data, DIR_ROWS[i].som, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    drain_outputs();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 4) begin
        tx_idle_pct = 20; rx_idle_pct = 79;
      end else if (p < 8) begin
        tx_idle_pct = 79; rx_idle_pct = 20;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      program_regs(p);
      run_phase(p, PHASE_ITEMS);
      if (p == 6) begin
        // output side stalls while input keeps coming, then input waits for the backlog
        hold_req   = 1'b1;
        saved_idle = tx_idle_pct;
        tx_idle_pct = 0;
        for (int k = 0; k < PRESSURE_ITEMS; k++)
          send_byte(8'($urandom_range(255)), 1'b0, 1'b0, 8'h00);
        tx_idle_pct = saved_idle;
      end
      drain_outputs();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && expected_bytes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (expected_bytes.size() != 0)
        $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/csx_pkg.sv
design/csx_stream_if.sv
design/csx_arx_unit.sv
design/csx_block_gen.sv
design/chacha20_stream_xor_top.sv
dv/tb_chacha20_stream_xor_top.sv
